[sv/tfc_pkg.sv]
// Shared types and constants for the triangle frustum cull core.
// Used by tfc_box_build, tfc_plane_eval and triangle_frustum_cull_core.
// No dependencies.
`default_nettype none

package tfc_pkg;

    // Configuration register indexes
    localparam int          CFG_IDX_W        = 3;
    localparam logic [2:0]  CFG_PLANE_0      = 3'd0;
    localparam logic [2:0]  CFG_HEIGHT_SCALE = 3'd6;
    localparam int          PLANE_REGS       = 6;
    localparam int          CFG_DATA_W       = 64;
    localparam logic [15:0] HEIGHT_SCALE_RST = 16'd256;

    // Pipeline depth: box (2), plane products, partial sums, final sum, reduce
    localparam int PIPE_DEPTH = 6;

    // Intermediate widths of the plane sum
    localparam int MID_W = 38;
    localparam int ACC_W = 56;

    // One input triangle
    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] bx;
        logic signed [15:0] by;
        logic signed [15:0] bz;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cz;
        logic        [15:0] err;
    } t_tri;

    // Box in doubled form: min+max per axis, max-min per axis
    // (x and z in world units, y span in Q.16 including the error widening)
    typedef struct packed {
        logic signed [16:0] sum_x;
        logic signed [16:0] sum_y;
        logic signed [16:0] sum_z;
        logic        [15:0] dif_x;
        logic        [33:0] dif_y;
        logic        [15:0] dif_z;
    } t_box;

    // Stage enables for the box builder
    typedef struct packed {
        logic en1;
        logic en2;
    } t_box_ctl;

    // Stage enables for one plane evaluator
    typedef struct packed {
        logic en3;
        logic en4;
        logic en5;
    } t_pln_ctl;

endpackage

`default_nettype wire

[sv/tfc_box_build.sv]
// Bounding box builder: min/max per axis and vertical error widening.
// Two register stages, advanced by enables from the top level.
// Depends on tfc_pkg.
`default_nettype none

module tfc_box_build import tfc_pkg::*; (
    input  wire logic        i_clk,
    input  wire t_box_ctl    i_ctl,
    input  wire t_tri        i_tri,
    input  wire logic [15:0] i_height_scale,
    output t_box             o_box
);

    function automatic logic signed [15:0] min3(input logic signed [15:0] a,
                                                input logic signed [15:0] b,
                                                input logic signed [15:0] c);
        logic signed [15:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [15:0] max3(input logic signed [15:0] a,
                                                input logic signed [15:0] b,
                                                input logic signed [15:0] c);
        logic signed [15:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    logic signed [15:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;

    logic signed [16:0] r_sum_x, r_sum_y, r_sum_z;
    logic        [15:0] r_dif_x, r_dif_y, r_dif_z;
    logic        [31:0] r_werr;

    t_box r_box;
    t_box n_box;

    // Stage 1: extremes per axis and the world error product
    always_comb begin
        lo_x = min3(i_tri.ax, i_tri.bx, i_tri.cx);
        hi_x = max3(i_tri.ax, i_tri.bx, i_tri.cx);
        lo_y = min3(i_tri.ay, i_tri.by, i_tri.cy);
        hi_y = max3(i_tri.ay, i_tri.by, i_tri.cy);
        lo_z = min3(i_tri.az, i_tri.bz, i_tri.cz);
        hi_z = max3(i_tri.az, i_tri.bz, i_tri.cz);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en1) begin
            r_sum_x <= {lo_x[15], lo_x} + {hi_x[15], hi_x};
            r_sum_y <= {lo_y[15], lo_y} + {hi_y[15], hi_y};
            r_sum_z <= {lo_z[15], lo_z} + {hi_z[15], hi_z};
            // span is 0..65535, so the low 16 bits are exact
            r_dif_x <= 16'(hi_x - lo_x);
            r_dif_y <= 16'(hi_y - lo_y);
            r_dif_z <= 16'(hi_z - lo_z);
            r_werr  <= 32'(i_tri.err) * 32'(i_height_scale);
        end
    end

    // Stage 2: vertical span in Q.16, widened up and down by the error
    always_comb begin
        n_box.sum_x = r_sum_x;
        n_box.sum_y = r_sum_y;
        n_box.sum_z = r_sum_z;
        n_box.dif_x = r_dif_x;
        n_box.dif_z = r_dif_z;
        n_box.dif_y = {2'd0, r_dif_y, 16'd0} + {1'b0, r_werr, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en2) begin
            r_box <= n_box;
        end
    end

    assign o_box = r_box;

endmodule

`default_nettype wire

[sv/tfc_plane_eval.sv]
// One plane test: n.(min+max) + |n|.(max-min) + 2w < 0, evaluated exactly.
// Three register stages: products, partial sums, final sum and sign.
// Depends on tfc_pkg.
`default_nettype none

module tfc_plane_eval import tfc_pkg::*; (
    input  wire logic                  i_clk,
    input  wire t_pln_ctl              i_ctl,
    input  wire t_box                  i_box,
    input  wire logic [CFG_DATA_W-1:0] i_plane,
    output logic                       o_cull
);

    logic signed [15:0] nx, ny, nz, w;
    logic        [15:0] abs_x, abs_y, abs_z;

    logic signed [32:0] r_xs, r_ys, r_zs;
    logic        [31:0] r_xd, r_zd;
    logic        [49:0] r_yd;

    logic [MID_W-1:0] r_t1, r_t2;
    logic [49:0]      r_yd4;

    logic [MID_W-1:0] n_t1, n_t2;
    logic [MID_W-1:0] mid_sum;
    logic [ACC_W-1:0] acc;

    logic r_cull;

    // Unpack the plane and take magnitudes of the normal
    always_comb begin
        nx    = i_plane[15:0];
        ny    = i_plane[31:16];
        nz    = i_plane[47:32];
        w     = i_plane[63:48];
        abs_x = nx[15] ? 16'(~i_plane[15:0] + 16'd1)  : i_plane[15:0];
        abs_y = ny[15] ? 16'(~i_plane[31:16] + 16'd1) : i_plane[31:16];
        abs_z = nz[15] ? 16'(~i_plane[47:32] + 16'd1) : i_plane[47:32];
    end

    // Stage 3: the six products
    always_ff @(posedge i_clk) begin
        if (i_ctl.en3) begin
            r_xs <= 33'(nx) * 33'(i_box.sum_x);
            r_ys <= 33'(ny) * 33'(i_box.sum_y);
            r_zs <= 33'(nz) * 33'(i_box.sum_z);
            r_xd <= 32'(abs_x) * 32'(i_box.dif_x);
            r_zd <= 32'(abs_z) * 32'(i_box.dif_z);
            r_yd <= 50'(abs_y) * 50'(i_box.dif_y);
        end
    end

    // Stage 4: partial sums in units of 2^16 (offset term is w * 2^15 there)
    always_comb begin
        n_t1 = {{(MID_W-31){w[15]}}, w, 15'd0}
             + {{(MID_W-33){r_xs[32]}}, r_xs}
             + {{(MID_W-32){1'b0}}, r_xd}
             + {{(MID_W-33){r_ys[32]}}, r_ys};
        n_t2 = {{(MID_W-33){r_zs[32]}}, r_zs}
             + {{(MID_W-32){1'b0}}, r_zd};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en4) begin
            r_t1  <= n_t1;
            r_t2  <= n_t2;
            r_yd4 <= r_yd;
        end
    end

    // Stage 5: scale back to Q.30, add the vertical span term, keep the sign
    always_comb begin
        mid_sum = r_t1 + r_t2;
        acc     = {{(ACC_W-MID_W-16){mid_sum[MID_W-1]}}, mid_sum, 16'd0}
                + {{(ACC_W-50){1'b0}}, r_yd4};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en5) begin
            r_cull <= acc[ACC_W-1];
        end
    end

    assign o_cull = r_cull;

endmodule

`default_nettype wire

[sv/triangle_frustum_cull_core.sv]
// Top level of the triangle frustum cull core: configuration registers,
// pipeline valid/enable chain, box builder and one evaluator per plane.
// Depends on tfc_pkg, tfc_box_build and tfc_plane_eval.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------
//  in      | to core   | i_in_valid / o_in_stall | i_vertex_{a,b,c}_{x,y,z},
//          |           |                         | i_geometric_error
//  out     | from core | o_out_valid/ i_out_stall| o_visible
//  cfg     | to core   | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// One word enters per cycle when nothing stalls, and words leave in the order they entered.
// Six register stages: two box stages, plane products, partial sums, final sum,
// and the reduction over planes into the output register.
// Each stage holds while it is full and the stage after it holds, so bubbles
// are squeezed out and the input stalls only when every stage is full.
// Reset clears the valid bits, zeroes the planes and sets height scale to 1.0.
`default_nettype none

module triangle_frustum_cull_core import tfc_pkg::*; #(
    parameter int NUM_PLANES = 6
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic signed [15:0]    i_vertex_a_x,
    input  wire logic signed [15:0]    i_vertex_a_y,
    input  wire logic signed [15:0]    i_vertex_a_z,
    input  wire logic signed [15:0]    i_vertex_b_x,
    input  wire logic signed [15:0]    i_vertex_b_y,
    input  wire logic signed [15:0]    i_vertex_b_z,
    input  wire logic signed [15:0]    i_vertex_c_x,
    input  wire logic signed [15:0]    i_vertex_c_y,
    input  wire logic signed [15:0]    i_vertex_c_z,
    input  wire logic        [15:0]    i_geometric_error,

    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_visible,

    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CFG_DATA_W-1:0] r_plane [PLANE_REGS];
    logic [15:0]           r_height_scale;

    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH-1:0] n_vld;
    logic [PIPE_DEPTH-1:0] en;

    t_tri      tri_in;
    t_box      box;
    t_box_ctl  box_ctl;
    t_pln_ctl  pln_ctl;

    logic [NUM_PLANES-1:0] cull;
    logic                  r_vis;

    // Configuration writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PLANE_REGS; k++) begin
                r_plane[k] <= '0;
            end
            r_height_scale <= HEIGHT_SCALE_RST;
        end else if (i_cfg_we) begin
            for (int k = 0; k < PLANE_REGS; k++) begin
                if (i_cfg_idx == CFG_PLANE_0 + CFG_IDX_W'(k)) begin
                    r_plane[k] <= i_cfg_data;
                end
            end
            if (i_cfg_idx == CFG_HEIGHT_SCALE) begin
                r_height_scale <= i_cfg_data[15:0];
            end
        end
    end

    // Stage enables: advance a stage when it is empty or its successor advances
    always_comb begin
        en[PIPE_DEPTH-1] = !r_vld[PIPE_DEPTH-1] || !i_out_stall;
        for (int k = PIPE_DEPTH-2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (en[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int k = 1; k < PIPE_DEPTH; k++) begin
            if (en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_stall  = !en[0];
    assign o_out_valid = r_vld[PIPE_DEPTH-1];

    // Box builder (stages 1 and 2)
    always_comb begin
        tri_in.ax  = i_vertex_a_x;
        tri_in.ay  = i_vertex_a_y;
        tri_in.az  = i_vertex_a_z;
        tri_in.bx  = i_vertex_b_x;
        tri_in.by  = i_vertex_b_y;
        tri_in.bz  = i_vertex_b_z;
        tri_in.cx  = i_vertex_c_x;
        tri_in.cy  = i_vertex_c_y;
        tri_in.cz  = i_vertex_c_z;
        tri_in.err = i_geometric_error;
        box_ctl.en1 = en[0];
        box_ctl.en2 = en[1];
        pln_ctl.en3 = en[2];
        pln_ctl.en4 = en[3];
        pln_ctl.en5 = en[4];
    end

    tfc_box_build u_box (
        .i_clk          (i_clk),
        .i_ctl          (box_ctl),
        .i_tri          (tri_in),
        .i_height_scale (r_height_scale),
        .o_box          (box)
    );

    // Plane evaluators (stages 3 to 5)
    for (genvar g = 0; g < NUM_PLANES; g++) begin : g_plane
        tfc_plane_eval u_plane (
            .i_clk   (i_clk),
            .i_ctl   (pln_ctl),
            .i_box   (box),
            .i_plane (r_plane[g]),
            .o_cull  (cull[g])
        );
    end

    // Stage 6: visible unless some plane culls
    always_ff @(posedge i_clk) begin
        if (en[PIPE_DEPTH-1]) begin
            r_vis <= ~|cull;
        end
    end

    assign o_visible = r_vis;

    // The input stalls only when every stage holds a word
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (&r_vld))
        else $error("input stalled with a bubble in the pipeline");

    // No backpressure downstream means no backpressure upstream
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_stall |-> !o_in_stall)
        else $error("input stalled while output is free");

    // Height scale write lands on the next edge
    a_scale_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_idx == CFG_HEIGHT_SCALE)
        |=> r_height_scale == $past(i_cfg_data[15:0]))
        else $error("height scale write lost");

    // First plane write lands on the next edge
    a_plane_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_idx == CFG_PLANE_0)
        |=> r_plane[0] == $past(i_cfg_data))
        else $error("plane write lost");

endmodule

`default_nettype wire
